// ===== rtl/core/b64lfa_pkg.sv =====
// shared constants, field widths and the base64 symbol decoder
package b64lfa_pkg;

   localparam int COLUMNS_DEF    = 80;
   localparam int ROWS_DEF       = 24;
   localparam int LINE_CHARS_DEF = 108;

   localparam int KIND_W  = 1;
   localparam int BYTE_W  = 8;
   localparam int RROW_W  = 5;
   localparam int RCOL_W  = 7;
   localparam int SEXT_W  = 6;

   localparam logic [KIND_W-1:0] KIND_SERIAL = 1'b0;
   localparam logic [KIND_W-1:0] KIND_READ   = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   // {bad, sextet}: bad is set for anything outside the alphabet, pad included
   function automatic logic [SEXT_W:0] sextet_of(input logic [BYTE_W-1:0] ch);
      logic [SEXT_W:0] r;
      r = {1'b1, {SEXT_W{1'b0}}};
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         r = {1'b0, 6'(ch - 8'h41)};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         r = {1'b0, 6'(ch - 8'h61 + 8'd26)};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b0, 6'(ch - 8'h30 + 8'd52)};
      end else if (ch == 8'h2B) begin
         r = {1'b0, 6'd62};
      end else if (ch == 8'h2F) begin
         r = {1'b0, 6'd63};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/b64lfa_if.sv =====
// valid/ready channel interfaces for requests and responses
interface b64lfa_req_if import b64lfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] serial_byte;
   logic [RROW_W-1:0] read_row;
   logic [RCOL_W-1:0] read_col;

   modport source  (output valid, kind, serial_byte, read_row, read_col, input ready);
   modport sink    (input valid, kind, serial_byte, read_row, read_col, output ready);
   modport monitor (input valid, ready, kind, serial_byte, read_row, read_col);
endinterface

interface b64lfa_rsp_if import b64lfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              frame_complete;
   logic [BYTE_W-1:0] cell_value;

   modport source  (output valid, frame_complete, cell_value, input ready);
   modport sink    (input valid, frame_complete, cell_value, output ready);
   modport monitor (input valid, ready, frame_complete, cell_value);
endinterface

// ===== rtl/core/b64lfa_store.sv =====
// frame and flags cell memory with its clearing sweep after reset
module b64lfa_store import b64lfa_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF,
   localparam int DEPTH  = (ROWS + 1) * COLUMNS,
   localparam int AW     = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data,
   output logic              busy
);

   localparam int FRAME_CELLS = ROWS * COLUMNS;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic              clearing_ff, clearing_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [BYTE_W-1:0] wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (32'(clr_addr_ff) == DEPTH - 1) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      we    = clearing_ff | wr_en;
      waddr = clearing_ff ? clr_addr_ff : wr_addr;
      wdata = wr_data;
      if (clearing_ff) begin
         // frame rows clear to spaces, the flags row to zero
         wdata = (32'(clr_addr_ff) < FRAME_CELLS) ? CHAR_SPACE : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

// ===== rtl/core/base64_line_frame_assembler_core.sv =====
// base64 line frame assembler: line buffer, decode sequencer and cell store
//
//  channel   dir   transaction
//  req_bus   in    serial byte (kind 0) or cell read (kind 1)
//  rsp_bus   out   one frame_complete / cell_value result per request
//
// ordinary serial bytes go straight to ST_FIN, reads pass ST_RDCELL; a
// newline ending a full-length line is checked in one pass over the single
// read port of the line buffer and, if it passes, decoded in a second,
// then the row columns past the decoded bytes are filled
// after reset a sweep clears all (ROWS+1)*COLUMNS cells of the cell store;
// requests wait for it
// one request is in flight at a time; a finished result waits in the
// response register while the next request is accepted
module base64_line_frame_assembler_core import b64lfa_pkg::*; #(
   parameter int COLUMNS    = COLUMNS_DEF,
   parameter int ROWS       = ROWS_DEF,
   parameter int LINE_CHARS = LINE_CHARS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   b64lfa_req_if.sink   req_bus,
   b64lfa_rsp_if.source rsp_bus
);

   localparam int NCHK  = 4 * (LINE_CHARS / 4);     // characters checked and decoded
   localparam int DEPTH = (ROWS + 1) * COLUMNS;
   localparam int SA_W  = $clog2(DEPTH);
   localparam int LB_AW = $clog2(LINE_CHARS);
   localparam int CNT_W = $clog2(LINE_CHARS + 2);   // saturates at LINE_CHARS+1
   localparam int IDX_W = $clog2(NCHK + 1);
   localparam int COL_W = $clog2(COLUMNS + 1);
   localparam int ROW_W = $clog2(ROWS + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_RDCELL = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_DECODE = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  char_count_ff, char_count_in;
   logic [ROW_W-1:0]  expected_ff, expected_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              pv_ff, pv_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic              bad_ff, bad_in;
   logic [SEXT_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0] linenum_ff, linenum_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [SA_W-1:0]   base_ff, base_in;
   logic              res_done_ff, res_done_in;
   logic [BYTE_W-1:0] res_cell_ff, res_cell_in;
   logic              inrange_ff, inrange_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [BYTE_W-1:0] rsp_cell_ff, rsp_cell_in;

   // line buffer: written one character per ordinary serial byte up to LINE_CHARS, no reset
   logic [BYTE_W-1:0] lb_mem [LINE_CHARS];
   logic [BYTE_W-1:0] lb_rdata_ff;
   logic              lb_we;
   logic [LB_AW-1:0]  lb_waddr;
   logic [LB_AW-1:0]  lb_raddr;

   // cell store port
   logic              st_we;
   logic [SA_W-1:0]   st_waddr;
   logic [BYTE_W-1:0] st_wdata;
   logic [SA_W-1:0]   st_raddr;
   logic [BYTE_W-1:0] st_rdata;
   logic              st_busy;

   logic              accept;
   logic              issue;
   logic [SEXT_W:0]   sx;
   logic [1:0]        lane;
   logic [BYTE_W-1:0] dec_byte;
   logic              col_open;
   logic              req_inrange;

   assign req_bus.ready = (state_ff == ST_IDLE) && !st_busy;
   assign accept        = req_bus.valid && req_bus.ready;

   // a read walks the checked characters in order, one per cycle
   assign issue    = ((state_ff == ST_CHECK) || (state_ff == ST_DECODE))
                     && (rd_idx_ff < IDX_W'(NCHK));
   assign lb_raddr = rd_idx_ff[LB_AW-1:0];
   assign sx       = sextet_of(lb_rdata_ff);
   assign lane     = pidx_ff[1:0];
   assign col_open = 32'(col_ff) < COLUMNS;

   // three bytes from four sextets, each from the previous and current sextet
   always_comb begin
      unique case (lane)
         2'd1:    dec_byte = {prev_ff, sx[5:4]};
         2'd2:    dec_byte = {prev_ff[3:0], sx[5:2]};
         2'd3:    dec_byte = {prev_ff[1:0], sx[5:0]};
         default: dec_byte = '0;
      endcase
   end

   assign req_inrange = (32'(req_bus.read_col) < COLUMNS) && (32'(req_bus.read_row) <= ROWS);

   always_comb begin
      lb_we    = 1'b0;
      lb_waddr = char_count_ff[LB_AW-1:0];
      st_we    = 1'b0;
      st_waddr = base_ff + SA_W'(col_ff);
      st_wdata = '0;
      st_raddr = req_inrange
                 ? SA_W'(32'(req_bus.read_row) * COLUMNS + 32'(req_bus.read_col)) : '0;

      state_in      = state_ff;
      char_count_in = char_count_ff;
      expected_in   = expected_ff;
      rd_idx_in     = issue ? rd_idx_ff + 1'b1 : rd_idx_ff;
      pv_in         = issue;
      pidx_in       = rd_idx_ff;
      bad_in        = bad_ff;
      prev_in       = prev_ff;
      linenum_in    = linenum_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      res_done_in   = res_done_ff;
      res_cell_in   = res_cell_ff;
      inrange_in    = inrange_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_done_in = 1'b0;
               res_cell_in = '0;
               state_in    = ST_FIN;
               if (req_bus.kind == KIND_READ) begin
                  inrange_in = req_inrange;
                  state_in   = ST_RDCELL;
               end else if (req_bus.serial_byte == CHAR_CR) begin
                  // carriage return ignored
               end else if (req_bus.serial_byte == CHAR_LF) begin
                  char_count_in = '0;
                  if (32'(char_count_ff) == LINE_CHARS) begin
                     rd_idx_in = '0;
                     bad_in    = 1'b0;
                     state_in  = ST_CHECK;
                  end
               end else if (32'(char_count_ff) < LINE_CHARS) begin
                  lb_we         = 1'b1;
                  char_count_in = char_count_ff + 1'b1;
               end else begin
                  // too long: hold at LINE_CHARS+1 until the newline
                  char_count_in = CNT_W'(LINE_CHARS + 1);
               end
            end
         end
         ST_RDCELL: begin
            res_cell_in = inrange_ff ? st_rdata : '0;
            state_in    = ST_FIN;
         end
         ST_CHECK: begin
            if (pv_ff) begin
               bad_in  = bad_ff | sx[SEXT_W];
               prev_in = sx[SEXT_W-1:0];
               if (pidx_ff == IDX_W'(1)) begin
                  linenum_in = {prev_ff, sx[5:4]};
               end
               if (pidx_ff == IDX_W'(NCHK - 1)) begin
                  if (bad_ff || sx[SEXT_W]) begin
                     state_in = ST_FIN;
                  end else if (32'(linenum_ff) != 32'(expected_ff)) begin
                     expected_in = '0;
                     state_in    = ST_FIN;
                  end else begin
                     base_in   = SA_W'(32'(expected_ff) * COLUMNS);
                     col_in    = '0;
                     rd_idx_in = '0;
                     state_in  = ST_DECODE;
                  end
               end
            end
         end
         ST_DECODE: begin
            if (pv_ff) begin
               prev_in = sx[SEXT_W-1:0];
               // byte 0 is the line number and is not stored
               if ((lane != 2'd0) && (pidx_ff != IDX_W'(1)) && col_open) begin
                  st_we    = 1'b1;
                  st_wdata = dec_byte;
                  col_in   = col_ff + 1'b1;
               end
               if (pidx_ff == IDX_W'(NCHK - 1)) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            // row bytes past the decoded data are zero
            if (col_open) begin
               st_we  = 1'b1;
               col_in = col_ff + 1'b1;
            end else begin
               state_in = ST_FIN;
               if (32'(expected_ff) == ROWS) begin
                  expected_in = '0;
                  res_done_in = 1'b1;
               end else begin
                  expected_in = expected_ff + 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register: loads when the finished result can be placed
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_done_in  = rsp_done_ff;
      rsp_cell_in  = rsp_cell_ff;
      if ((state_ff == ST_FIN) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = res_done_ff;
         rsp_cell_in  = res_cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         char_count_ff <= '0;
         expected_ff   <= '0;
         rd_idx_ff     <= '0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         char_count_ff <= char_count_in;
         expected_ff   <= expected_in;
         rd_idx_ff     <= rd_idx_in;
         pv_ff         <= pv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      bad_ff      <= bad_in;
      prev_ff     <= prev_in;
      linenum_ff  <= linenum_in;
      col_ff      <= col_in;
      base_ff     <= base_in;
      res_done_ff <= res_done_in;
      res_cell_ff <= res_cell_in;
      inrange_ff  <= inrange_in;
      rsp_done_ff <= rsp_done_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // line buffer memory
   always_ff @(posedge clock) begin
      if (lb_we) begin
         lb_mem[lb_waddr] <= req_bus.serial_byte;
      end
      lb_rdata_ff <= lb_mem[lb_raddr];
   end

   b64lfa_store #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata),
      .busy    (st_busy)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.frame_complete = rsp_done_ff;
   assign rsp_bus.cell_value     = rsp_cell_ff;

   // no request is taken while the store sweep runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !st_busy)
      else $error("request accepted during store clear");

   // store writes only come from the decode and fill steps
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      st_we |-> ((state_ff == ST_DECODE) || (state_ff == ST_FILL)))
      else $error("store write outside decode");

   // a completed frame leaves the line counter at zero
   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && res_done_ff) |-> (expected_ff == '0))
      else $error("frame completion without counter wrap");

   // a result is only produced after a request was taken
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response without finished request");

endmodule
